@@ rtl/rei_pkg.sv @@
// Shared types, widths and helpers for the quadrilateral edge intersection test.
package rei_pkg;

  // Coordinate and arithmetic widths
  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int OrntW      = ProdW + 1;
  localparam int NumCorners = 4;
  localparam int NumRegs    = 2 * NumCorners;
  localparam int RegIdxW    = $clog2(NumRegs);
  localparam int AddrW      = RegIdxW + 2;
  localparam int DataW      = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [OrntW-1:0]  ornt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // Per-stage load enables from the handshake control
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

  // Sign class of one orientation value
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // Everything the final stage needs for one item
  typedef struct packed {
    sgn_t [NumCorners-1:0][NumCorners-1:0] pt_vs_edge;  // [own edge][query point]
    sgn_t [NumCorners-1:0][NumCorners-1:0] cn_vs_qedge; // [query edge][own corner]
    logic [NumCorners-1:0][NumCorners-1:0] pt_in_box;   // [query point][own edge]
    logic [NumCorners-1:0][NumCorners-1:0] cn_in_box;   // [query edge][own corner]
    logic                                  func;
  } orient_t;

  // Point inside the closed bounding box of a segment, given the point's
  // offsets from both segment ends.
  function automatic logic span_hit(input diff_t ax, input diff_t bx,
                                    input diff_t ay, input diff_t by);
    logic x_lo, x_hi, y_lo, y_hi;
    x_lo = !ax[DiffW-1] || !bx[DiffW-1];
    x_hi = ax[DiffW-1] || (ax == '0) || bx[DiffW-1] || (bx == '0);
    y_lo = !ay[DiffW-1] || !by[DiffW-1];
    y_hi = ay[DiffW-1] || (ay == '0) || by[DiffW-1] || (by == '0);
    return x_lo && x_hi && y_lo && y_hi;
  endfunction

endpackage

@@ rtl/rect_edge_intersection_test.sv @@
// Top level of the quadrilateral edge intersection test.
//
// Tests a query against a quadrilateral whose corners are held in eight APB
// registers (box_x0 at 0x00 .. box_y3 at 0x1C, 16-bit signed, reset 0). With
// func_i 0 the query is the segment from point 0 to point 1; with func_i 1 it
// is a second quadrilateral whose four closed edges are all tested. hit_o is
// 1 when any query edge crosses or touches any own edge. The block takes one
// item every cycle while in_stall_o is low; offsets, 17x17 products, exact
// orientation signs and the final OR each take one register stage, and all
// 32 orientations have their own multipliers.
// Stalls fill bubbles inside the pipeline before they reach in_stall_o.
// Write the corners only while no item is in flight.
module rect_edge_intersection_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rei_pkg::AddrW-1:0]  paddr,
  input  logic [rei_pkg::DataW-1:0]  pwdata,
  output logic [rei_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  // query channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic signed [rei_pkg::CoordW-1:0] qx0_i,
  input  logic signed [rei_pkg::CoordW-1:0] qy0_i,
  input  logic signed [rei_pkg::CoordW-1:0] qx1_i,
  input  logic signed [rei_pkg::CoordW-1:0] qy1_i,
  input  logic signed [rei_pkg::CoordW-1:0] qx2_i,
  input  logic signed [rei_pkg::CoordW-1:0] qy2_i,
  input  logic signed [rei_pkg::CoordW-1:0] qx3_i,
  input  logic signed [rei_pkg::CoordW-1:0] qy3_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o
);

  localparam int N = rei_pkg::NumCorners;

  rei_pkg::pt_t [N-1:0] corner;
  rei_pkg::pt_t [N-1:0] qpt;
  rei_pkg::pipe_ld_t    ld;
  rei_pkg::orient_t     flags;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign qpt[0] = '{x: qx0_i, y: qy0_i};
  assign qpt[1] = '{x: qx1_i, y: qy1_i};
  assign qpt[2] = '{x: qx2_i, y: qy2_i};
  assign qpt[3] = '{x: qx3_i, y: qy3_i};

  // Stage advances when it is empty or the next one moves
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld.ld1 = rdy1;
  assign ld.ld2 = rdy2;
  assign ld.ld3 = rdy3;
  assign ld.ld4 = rdy4;

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  rei_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .corner_o (corner)
  );

  rei_geom u_geom (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .func_i  (func_i),
    .q_i     (qpt),
    .c_i     (corner),
    .flags_o (flags)
  );

  rei_decide u_decide (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .flags_i (flags),
    .hit_o   (hit_o)
  );

endmodule

@@ rtl/rei_cfg.sv @@
// APB register file holding the four corners of the own quadrilateral.
module rei_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rei_pkg::AddrW-1:0]  paddr,
  input  logic [rei_pkg::DataW-1:0]  pwdata,
  output logic [rei_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output rei_pkg::pt_t [rei_pkg::NumCorners-1:0] corner_o
);

  logic [rei_pkg::CoordW-1:0] box_q [rei_pkg::NumRegs];
  logic [rei_pkg::RegIdxW-1:0] reg_idx;
  logic                        wr_en;

  assign reg_idx = paddr[rei_pkg::AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rei_pkg::NumRegs; i++) begin
        box_q[i] <= '0;
      end
    end else if (wr_en) begin
      box_q[reg_idx] <= pwdata[rei_pkg::CoordW-1:0];
    end
  end

  // Read back, zero extended
  assign prdata = rei_pkg::DataW'(box_q[reg_idx]);

  for (genvar j = 0; j < rei_pkg::NumCorners; j++) begin : g_corner
    assign corner_o[j].x = rei_pkg::coord_t'(box_q[2*j]);
    assign corner_o[j].y = rei_pkg::coord_t'(box_q[2*j+1]);
  end

endmodule

@@ rtl/rei_geom.sv @@
// Offset, product and orientation-sign stages (pipeline stages 1 to 3).
module rei_geom (
  input  logic                                   clk_i,
  input  rei_pkg::pipe_ld_t                      ld_i,
  input  logic                                   func_i,
  input  rei_pkg::pt_t [rei_pkg::NumCorners-1:0] q_i,
  input  rei_pkg::pt_t [rei_pkg::NumCorners-1:0] c_i,
  output rei_pkg::orient_t                       flags_o
);

  localparam int N = rei_pkg::NumCorners;

  // Stage 1: coordinate offsets
  rei_pkg::diff_t pd_x_q [N][N];  // [query point][own corner] = q - c
  rei_pkg::diff_t pd_y_q [N][N];
  rei_pkg::diff_t ed_x_q [N];     // own edge direction
  rei_pkg::diff_t ed_y_q [N];
  rei_pkg::diff_t qd_x_q [N];     // query edge direction
  rei_pkg::diff_t qd_y_q [N];
  logic           func1_q;

  // Stage 2: products and box tests
  rei_pkg::prod_t p1a_q [N][N], p1b_q [N][N];  // [own edge][query point]
  rei_pkg::prod_t p2a_q [N][N], p2b_q [N][N];  // [query edge][own corner]
  logic [N-1:0][N-1:0] pib_q, cib_q;
  logic           func2_q;

  // Stage 3: orientation signs
  rei_pkg::orient_t flags_q;

  for (genvar i = 0; i < N; i++) begin : g_s1_i
    localparam int Pi = (i + N - 1) % N;
    always_ff @(posedge clk_i) begin
      if (ld_i.ld1) begin
        ed_x_q[i] <= rei_pkg::diff_t'(c_i[i].x) - rei_pkg::diff_t'(c_i[Pi].x);
        ed_y_q[i] <= rei_pkg::diff_t'(c_i[i].y) - rei_pkg::diff_t'(c_i[Pi].y);
        qd_x_q[i] <= rei_pkg::diff_t'(q_i[i].x) - rei_pkg::diff_t'(q_i[Pi].x);
        qd_y_q[i] <= rei_pkg::diff_t'(q_i[i].y) - rei_pkg::diff_t'(q_i[Pi].y);
      end
    end
    for (genvar j = 0; j < N; j++) begin : g_s1_j
      always_ff @(posedge clk_i) begin
        if (ld_i.ld1) begin
          pd_x_q[i][j] <= rei_pkg::diff_t'(q_i[i].x) - rei_pkg::diff_t'(c_i[j].x);
          pd_y_q[i][j] <= rei_pkg::diff_t'(q_i[i].y) - rei_pkg::diff_t'(c_i[j].y);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      func1_q <= func_i;
    end
  end

  // Stage 2: orient(c_prev, c_e, q_i) and orient(q_prev, q_k, c_j) halves
  for (genvar a = 0; a < N; a++) begin : g_s2_a
    localparam int Pa = (a + N - 1) % N;
    for (genvar b = 0; b < N; b++) begin : g_s2_b
      rei_pkg::prod_t p1a, p1b, p2a, p2b;
      always_comb begin
        // own edge a against query point b
        p1a = ed_x_q[a] * pd_y_q[b][Pa];
        p1b = ed_y_q[a] * pd_x_q[b][Pa];
        // query edge a against own corner b (sign folded into operand order)
        p2a = qd_y_q[a] * pd_x_q[Pa][b];
        p2b = qd_x_q[a] * pd_y_q[Pa][b];
      end
      always_ff @(posedge clk_i) begin
        if (ld_i.ld2) begin
          p1a_q[a][b] <= p1a;
          p1b_q[a][b] <= p1b;
          p2a_q[a][b] <= p2a;
          p2b_q[a][b] <= p2b;
          // query point b in box of own edge a
          pib_q[b][a] <= rei_pkg::span_hit(pd_x_q[b][Pa], pd_x_q[b][a],
                                           pd_y_q[b][Pa], pd_y_q[b][a]);
          // own corner b in box of query edge a
          cib_q[a][b] <= rei_pkg::span_hit(pd_x_q[Pa][b], pd_x_q[a][b],
                                           pd_y_q[Pa][b], pd_y_q[a][b]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      func2_q <= func1_q;
    end
  end

  // Stage 3: exact difference, keep only its sign class
  for (genvar a = 0; a < N; a++) begin : g_s3_a
    for (genvar b = 0; b < N; b++) begin : g_s3_b
      rei_pkg::ornt_t o1, o2;
      always_comb begin
        o1 = rei_pkg::ornt_t'(p1a_q[a][b]) - rei_pkg::ornt_t'(p1b_q[a][b]);
        o2 = rei_pkg::ornt_t'(p2a_q[a][b]) - rei_pkg::ornt_t'(p2b_q[a][b]);
      end
      always_ff @(posedge clk_i) begin
        if (ld_i.ld3) begin
          flags_q.pt_vs_edge[a][b].neg   <= o1[rei_pkg::OrntW-1];
          flags_q.pt_vs_edge[a][b].zero  <= (o1 == '0);
          flags_q.cn_vs_qedge[a][b].neg  <= o2[rei_pkg::OrntW-1];
          flags_q.cn_vs_qedge[a][b].zero <= (o2 == '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      flags_q.pt_in_box <= pib_q;
      flags_q.cn_in_box <= cib_q;
      flags_q.func      <= func2_q;
    end
  end

  assign flags_o = flags_q;

endmodule

@@ rtl/rei_decide.sv @@
// Final stage: combines orientation signs into per edge pair hits and ORs them.
module rei_decide (
  input  logic                   clk_i,
  input  rei_pkg::pipe_ld_t      ld_i,
  input  rei_pkg::orient_t       flags_i,
  output logic                   hit_o
);

  localparam int N = rei_pkg::NumCorners;

  logic [N-1:0][N-1:0] pair_hit;  // [query edge][own edge]
  logic [N-1:0]        qedge_en;
  logic                hit_q;

  // Segment mode uses only the query edge from point 0 to point 1
  always_comb begin
    qedge_en    = '0;
    qedge_en[1] = 1'b1;
    if (flags_i.func) begin
      qedge_en = '1;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_k
    localparam int Pk = (k + N - 1) % N;
    for (genvar e = 0; e < N; e++) begin : g_e
      localparam int Pe = (e + N - 1) % N;
      rei_pkg::sgn_t v1, v2, v3, v4;
      logic          crossing, touch;
      always_comb begin
        v1 = flags_i.pt_vs_edge[e][Pk];
        v2 = flags_i.pt_vs_edge[e][k];
        v3 = flags_i.cn_vs_qedge[k][Pe];
        v4 = flags_i.cn_vs_qedge[k][e];
        // proper crossing: strictly opposite signs on both sides
        crossing = !v1.zero && !v2.zero && (v1.neg != v2.neg) &&
                   !v3.zero && !v4.zero && (v3.neg != v4.neg);
        // endpoint lying on the other segment
        touch = (v1.zero && flags_i.pt_in_box[Pk][e]) ||
                (v2.zero && flags_i.pt_in_box[k][e]) ||
                (v3.zero && flags_i.cn_in_box[k][Pe]) ||
                (v4.zero && flags_i.cn_in_box[k][e]);
        pair_hit[k][e] = qedge_en[k] && (crossing || touch);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld4) begin
      hit_q <= |pair_hit;
    end
  end

  assign hit_o = hit_q;

endmodule
